### src/trilinear_volume_sampler_unit_macros.svh
// Assertion macros shared by the trilinear volume sampler RTL.
`ifndef TRILINEAR_VOLUME_SAMPLER_UNIT_MACROS_SVH
`define TRILINEAR_VOLUME_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define TLVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define TLVS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tlvs_pkg.sv
// Shared constants, codes and types of the trilinear volume sampler.
package tlvs_pkg;

    localparam int MAX_DIM    = 32;
    localparam int VOXEL_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int ADDR_W     = 15;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    localparam int SIZE_W  = 6;
    localparam int COORD_W = 16;
    localparam int OUT_W   = 24;
    localparam int CELL_W  = $clog2(MAX_DIM);
    localparam int W_W     = FRAC_BITS + 1;          // weight 0..2^FRAC_BITS
    localparam int ACC_W   = VOXEL_BITS + FRAC_BITS; // scaled voxel / blend value
    localparam int IP_W    = COORD_W - 1 - FRAC_BITS; // integer part of a coordinate

    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // Input beat kinds (tuser)
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    // Cell and weight picked for one axis
    typedef struct packed {
        logic [CELL_W-1:0] pos;
        logic [W_W-1:0]    weight;
    } axis_t;

endpackage

### src/tlvs_voxel_store.sv
// Voxel memory with one write port and one registered read port.
module tlvs_voxel_store (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [tlvs_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [tlvs_pkg::VOXEL_BITS-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [tlvs_pkg::ADDR_W-1:0]     rd_addr,
    output logic [tlvs_pkg::VOXEL_BITS-1:0] rd_data
);
    import tlvs_pkg::*;

    logic [VOXEL_BITS-1:0] mem [STORE_DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/tlvs_axis.sv
// Per-axis clamp: picks the cell and the blend weight from one coordinate.
module tlvs_axis (
    input  logic [tlvs_pkg::COORD_W-1:0] coord,
    input  logic [tlvs_pkg::SIZE_W-1:0]  size,
    output tlvs_pkg::axis_t              axis
);
    import tlvs_pkg::*;

    logic              neg;
    logic [IP_W-1:0]   ipart;
    logic [SIZE_W-1:0] lim;
    logic              over;

    always_comb begin
        neg   = coord[COORD_W-1];
        ipart = coord[COORD_W-2:FRAC_BITS];
        lim   = size - SIZE_W'(2);
        over  = ipart > {{(IP_W-SIZE_W){1'b0}}, lim};

        if (neg) begin
            // below zero: first cell, no step
            axis.pos    = '0;
            axis.weight = '0;
        end else if (over) begin
            // past the last cell: last cell, full step
            axis.pos    = lim[CELL_W-1:0];
            axis.weight = {1'b1, {FRAC_BITS{1'b0}}};
        end else begin
            axis.pos    = ipart[CELL_W-1:0];
            axis.weight = {1'b0, coord[FRAC_BITS-1:0]};
        end
    end

endmodule

### src/tlvs_lerp.sv
// Shared lerp unit: a + floor((b - a) * w / 2^FRAC_BITS).
module tlvs_lerp (
    input  logic [tlvs_pkg::ACC_W-1:0] a,
    input  logic [tlvs_pkg::ACC_W-1:0] b,
    input  logic [tlvs_pkg::W_W-1:0]   w,
    output logic [tlvs_pkg::ACC_W-1:0] y
);
    import tlvs_pkg::*;

    localparam int PROD_W = ACC_W + W_W + 2;

    logic signed [ACC_W:0]    diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;

    always_comb begin
        diff    = $signed({b[ACC_W-1], b}) - $signed({a[ACC_W-1], a});
        prod    = PROD_W'(diff) * PROD_W'($signed({1'b0, w}));
        // arithmetic shift floors toward minus infinity
        shifted = prod >>> FRAC_BITS;
        // result lies between a and b, so ACC_W bits hold it
        y       = a + shifted[ACC_W-1:0];
    end

endmodule

### src/trilinear_volume_sampler_unit.sv
// Trilinear volume sampler top level: stream ports, sequencer and datapath.
//
// A write beat (tuser = 0) stores one voxel and gives no result. A sample
// beat (tuser = 1) passes through the states SETUP, ADDR, READ, DRAIN,
// LY0, LY1 and LZ before the input side is ready again: SETUP picks cells
// and weights, ADDR forms the base address, READ reads the eight neighbours
// in turn through the single read port of the memory, and the x-axis
// blends run on the shared lerp unit as neighbour pairs arrive, followed by
// two y-axis blends and one z-axis blend on that same unit. The result
// register frees the input side at once; if the previous result is still
// waiting, the final blend waits for it. The voxel memory has no reset and
// no clearing pass: a sample must only touch voxels that were written.
`include "trilinear_volume_sampler_unit_macros.svh"

module trilinear_volume_sampler_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [tlvs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlvs_pkg::SIZE_W-1:0]       cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [14:0] voxel_addr, [30:15] voxel_value, [46:31] coord_x,
    // [62:47] coord_y, [78:63] coord_z, [79] zero
    input  logic [79:0]                       s_tdata,
    // [0] op
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] interp_value
    output logic [tlvs_pkg::OUT_W-1:0]        m_tdata
);
    import tlvs_pkg::*;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_SETUP = 3'd1;
    localparam logic [ST_W-1:0] ST_ADDR  = 3'd2;
    localparam logic [ST_W-1:0] ST_READ  = 3'd3;
    localparam logic [ST_W-1:0] ST_DRAIN = 3'd4;
    localparam logic [ST_W-1:0] ST_LY0   = 3'd5;
    localparam logic [ST_W-1:0] ST_LY1   = 3'd6;
    localparam logic [ST_W-1:0] ST_LZ    = 3'd7;

    localparam int NBR_W = 3;                  // eight neighbours
    localparam int T1_W  = SIZE_W + CELL_W;    // sx * cy
    localparam int T2_W  = ADDR_W + CELL_W;    // sx*sy * cz
    localparam int SS_W  = 2 * SIZE_W;         // sx * sy

    // unpacked input fields
    logic [ADDR_W-1:0]     in_addr;
    logic [VOXEL_BITS-1:0] in_value;
    logic [COORD_W-1:0]    in_cx;
    logic [COORD_W-1:0]    in_cy;
    logic [COORD_W-1:0]    in_cz;

    assign in_addr  = s_tdata[14:0];
    assign in_value = s_tdata[30:15];
    assign in_cx    = s_tdata[46:31];
    assign in_cy    = s_tdata[62:47];
    assign in_cz    = s_tdata[78:63];

    logic [ST_W-1:0] state_reg, state_next;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [SIZE_W-1:0] eff_x, eff_y, eff_z;

    logic [COORD_W-1:0] coord_x_reg, coord_y_reg, coord_z_reg;
    axis_t ax_x, ax_y, ax_z;
    axis_t ax_x_reg, ax_y_reg, ax_z_reg;

    logic [SIZE_W-1:0] sx_reg;
    logic [SS_W-1:0]   sxsy_full;
    logic [ADDR_W-1:0] sxsy_reg;
    logic [T1_W-1:0]   t1;
    logic [T2_W-1:0]   t2;
    logic [ADDR_W-1:0] base_reg, base_next;

    logic [NBR_W-1:0]  k_reg;
    logic [NBR_W-1:0]  dat_idx_reg;
    logic              rd_valid_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [VOXEL_BITS-1:0] rd_data;
    logic [ACC_W-1:0]  vox_scaled;

    logic [ACC_W-1:0] hold_reg;
    logic [ACC_W-1:0] xr_reg [4];
    logic [ACC_W-1:0] y0_reg, y1_reg;

    logic [ACC_W-1:0] lerp_a, lerp_b, lerp_y;
    logic [W_W-1:0]   lerp_w;

    logic              in_acc;
    logic              wr_en;
    logic              out_free;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    // no beat is taken while reset is held
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign wr_en    = in_acc && (s_tuser == OP_WRITE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SIZE_X: size_x_reg <= cfg_wdata;
                REG_SIZE_Y: size_y_reg <= cfg_wdata;
                REG_SIZE_Z: size_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sizes clamped to 2..MAX_DIM
    always_comb begin
        eff_x = (size_x_reg < SIZE_W'(2)) ? SIZE_W'(2) :
                (size_x_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_x_reg;
        eff_y = (size_y_reg < SIZE_W'(2)) ? SIZE_W'(2) :
                (size_y_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_y_reg;
        eff_z = (size_z_reg < SIZE_W'(2)) ? SIZE_W'(2) :
                (size_z_reg > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_z_reg;
    end

    tlvs_axis u_axis_x (.coord(coord_x_reg), .size(eff_x), .axis(ax_x));
    tlvs_axis u_axis_y (.coord(coord_y_reg), .size(eff_y), .axis(ax_y));
    tlvs_axis u_axis_z (.coord(coord_z_reg), .size(eff_z), .axis(ax_z));

    // base address of the cell corner
    always_comb begin
        t1        = T1_W'(sx_reg) * T1_W'(ax_y_reg.pos);
        t2        = T2_W'(sxsy_reg) * T2_W'(ax_z_reg.pos);
        sxsy_full = SS_W'(eff_x) * SS_W'(eff_y);
        base_next = ADDR_W'(ax_x_reg.pos) + ADDR_W'(t1) + t2[ADDR_W-1:0];
    end

    // neighbour k: bit 0 steps x, bit 1 steps y, bit 2 steps z
    always_comb begin
        rd_en   = (state_reg == ST_READ);
        rd_addr = base_reg
                + (k_reg[0] ? ADDR_W'(1) : '0)
                + (k_reg[1] ? ADDR_W'(sx_reg) : '0)
                + (k_reg[2] ? sxsy_reg : '0);
    end

    tlvs_voxel_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (in_addr),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign vox_scaled = {rd_data, {FRAC_BITS{1'b0}}};

    // operand select for the shared lerp unit
    always_comb begin
        case (state_reg)
            ST_LY0: begin
                lerp_a = xr_reg[0];
                lerp_b = xr_reg[1];
                lerp_w = ax_y_reg.weight;
            end
            ST_LY1: begin
                lerp_a = xr_reg[2];
                lerp_b = xr_reg[3];
                lerp_w = ax_y_reg.weight;
            end
            ST_LZ: begin
                lerp_a = y0_reg;
                lerp_b = y1_reg;
                lerp_w = ax_z_reg.weight;
            end
            default: begin
                lerp_a = hold_reg;
                lerp_b = vox_scaled;
                lerp_w = ax_x_reg.weight;
            end
        endcase
    end

    tlvs_lerp u_lerp (.a(lerp_a), .b(lerp_b), .w(lerp_w), .y(lerp_y));

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc && (s_tuser == OP_SAMPLE)) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_ADDR;
            ST_ADDR:  state_next = ST_READ;
            ST_READ:  if (k_reg == '1) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_LY0;
            ST_LY0:   state_next = ST_LY1;
            ST_LY1:   state_next = ST_LZ;
            ST_LZ:    if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            if (state_reg == ST_READ) begin
                k_reg <= k_reg + NBR_W'(1);
            end else begin
                k_reg <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            coord_x_reg <= in_cx;
            coord_y_reg <= in_cy;
            coord_z_reg <= in_cz;
        end
        if (state_reg == ST_SETUP) begin
            ax_x_reg <= ax_x;
            ax_y_reg <= ax_y;
            ax_z_reg <= ax_z;
            sx_reg   <= eff_x;
            sxsy_reg <= ADDR_W'(sxsy_full);
        end
        if (state_reg == ST_ADDR) begin
            base_reg <= base_next;
        end
        dat_idx_reg <= k_reg;
        // even neighbour waits, odd neighbour completes an x blend
        if (rd_valid_reg) begin
            if (!dat_idx_reg[0]) begin
                hold_reg <= vox_scaled;
            end else begin
                xr_reg[dat_idx_reg[2:1]] <= lerp_y;
            end
        end
        if (state_reg == ST_LY0) begin
            y0_reg <= lerp_y;
        end
        if (state_reg == ST_LY1) begin
            y1_reg <= lerp_y;
        end
        if ((state_reg == ST_LZ) && out_free) begin
            m_tdata_reg <= lerp_y;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_LZ) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // checks
    `TLVS_ASSERT_IMP(a_setup_after_sample, state_reg == ST_SETUP, $past(in_acc && (s_tuser == OP_SAMPLE)), "setup entered without a sample beat")
    `TLVS_ASSERT_IMP(a_read_window, rd_valid_reg, (state_reg == ST_READ) || (state_reg == ST_DRAIN), "read data outside the read window")
    `TLVS_ASSERT_NXT(a_last_read, (state_reg == ST_READ) && (k_reg == '1), (state_reg == ST_DRAIN) && rd_valid_reg && (dat_idx_reg == '1), "last neighbour not drained")
    `TLVS_ASSERT_NXT(a_result_out, (state_reg == ST_LZ) && out_free, m_tvalid && (state_reg == ST_IDLE), "final blend did not post a result")

endmodule
